FILE: rtl/core/assert_macros.svh
// assertion macros used by the alarm detector rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, off while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/core/pmad_pkg.sv
// types and constants for the power monitor alarm detector
`default_nettype none

package pmad_pkg;

	typedef struct packed {
		logic              poll_ok;
		logic              armed;
		logic signed [15:0] pv_watts;
		logic signed [15:0] grid_watts;
		logic [6:0]        charge_percent;
	} item_t;

	typedef struct packed {
		logic              solar_started;
		logic              solar_stopped;
		logic              battery_low;
		logic              battery_recovered;
		logic              grid_lost;
		logic              grid_back;
		logic              logger_failed;
		logic signed [15:0] pv_report;
		logic signed [15:0] grid_report;
		logic [6:0]        charge_report;
	} result_t;

	// configuration register indexes
	localparam logic [1:0] CFG_SOLAR_ON   = 2'd0;
	localparam logic [1:0] CFG_GRID_ON    = 2'd1;
	localparam logic [1:0] CFG_LOGGER_ON  = 2'd2;
	localparam logic [1:0] CFG_BATT_LOW   = 2'd3;

	localparam logic [6:0] BATT_LOW_RESET = 7'd20;

	localparam logic signed [15:0] SOLAR_ON_W    = 16'sd50;
	localparam logic signed [15:0] SOLAR_OFF_W   = 16'sd20;
	localparam logic signed [15:0] GRID_ACTIVE_W = 16'sd100;
	localparam logic signed [15:0] GRID_ACTIVE_N = -16'sd100;

	// a counter at this value completes the third reading in a row
	localparam logic [1:0] DEBOUNCE_LAST = 2'd2;
	localparam logic [2:0] FAIL_LIMIT    = 3'd5;
	localparam logic [7:0] RECOVER_MARGIN = 8'd5;
	localparam logic [7:0] CHARGE_FULL    = 8'd100;

endpackage

`default_nettype wire

FILE: rtl/core/power_monitor_alarm_detector.sv
// power monitor alarm detector: solar, battery, grid and logger alarms
// path: input register, then result register; a result stall can hold an item between them
// throughput: one item per cycle unless stalled; detectors are compares and 2/3-bit counters
// the input side stalls only when the input register is full and the result is stalled
// reset: asynchronous, clears detector state, valid flags and config (threshold to 20)
`default_nettype none

`include "assert_macros.svh"

module power_monitor_alarm_detector (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 item_valid,
	output logic                item_stall,
	input  pmad_pkg::item_t     item,
	output logic                result_valid,
	input  wire                 result_stall,
	output pmad_pkg::result_t   result,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire [1:0]           cfg_index,
	input  wire [6:0]           cfg_data
);

	// configuration
	logic       solar_alerts_on_q;
	logic       grid_alerts_on_q;
	logic       logger_alerts_on_q;
	logic [6:0] battery_low_percent_q;

	// detector state
	logic       solar_on_q;
	logic [1:0] solar_count_q;
	logic       battery_is_low_q;
	logic       grid_seen_q;
	logic       grid_down_q;
	logic [1:0] grid_count_q;
	logic [2:0] fail_count_q;
	logic       fail_reported_q;

	logic       solar_on_d;
	logic [1:0] solar_count_d;
	logic       battery_is_low_d;
	logic       grid_seen_d;
	logic       grid_down_d;
	logic [1:0] grid_count_d;
	logic [2:0] fail_count_d;
	logic       fail_reported_d;

	// pipeline
	logic              valid_s1;
	pmad_pkg::item_t   item_s1;
	logic              valid_s2;
	pmad_pkg::result_t result_s2;
	pmad_pkg::result_t res_d;

	logic       adv_s2;
	logic       take_s1;
	logic       mains_live;
	logic [7:0] rec_sum;
	logic [7:0] rec_level;

	assign cfg_ready    = 1'b1;
	assign adv_s2       = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall   = valid_s1 && valid_s2 && result_stall;
	assign take_s1      = item_valid && !item_stall;
	assign result_valid = valid_s2;
	assign result       = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			solar_alerts_on_q     <= 1'b0;
			grid_alerts_on_q      <= 1'b0;
			logger_alerts_on_q    <= 1'b0;
			battery_low_percent_q <= pmad_pkg::BATT_LOW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pmad_pkg::CFG_SOLAR_ON:  solar_alerts_on_q     <= cfg_data[0];
				pmad_pkg::CFG_GRID_ON:   grid_alerts_on_q      <= cfg_data[0];
				pmad_pkg::CFG_LOGGER_ON: logger_alerts_on_q    <= cfg_data[0];
				pmad_pkg::CFG_BATT_LOW:  battery_low_percent_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign mains_live  = (item_s1.grid_watts > pmad_pkg::GRID_ACTIVE_W) ||
		(item_s1.grid_watts < pmad_pkg::GRID_ACTIVE_N);
	assign rec_sum     = {1'b0, battery_low_percent_q} + pmad_pkg::RECOVER_MARGIN;
	assign rec_level   = (rec_sum <= pmad_pkg::CHARGE_FULL) ? rec_sum : pmad_pkg::CHARGE_FULL;

	always_comb begin
		res_d            = '0;
		solar_on_d       = solar_on_q;
		solar_count_d    = solar_count_q;
		battery_is_low_d = battery_is_low_q;
		grid_seen_d      = grid_seen_q;
		grid_down_d      = grid_down_q;
		grid_count_d     = grid_count_q;
		fail_count_d     = fail_count_q;
		fail_reported_d  = fail_reported_q;

		// logger
		if (item_s1.poll_ok) begin
			fail_count_d    = '0;
			fail_reported_d = 1'b0;
		end else begin
			if (fail_count_q < pmad_pkg::FAIL_LIMIT) begin
				fail_count_d = fail_count_q + 3'd1;
			end
			if (fail_count_d == pmad_pkg::FAIL_LIMIT && !fail_reported_q) begin
				fail_reported_d   = 1'b1;
				res_d.logger_failed = logger_alerts_on_q;
			end
		end

		if (item_s1.poll_ok && item_s1.armed) begin
			// solar
			if (solar_alerts_on_q) begin
				if (!solar_on_q && item_s1.pv_watts > pmad_pkg::SOLAR_ON_W) begin
					if (solar_count_q == pmad_pkg::DEBOUNCE_LAST) begin
						solar_on_d          = 1'b1;
						solar_count_d       = '0;
						res_d.solar_started = 1'b1;
						res_d.pv_report     = item_s1.pv_watts;
					end else begin
						solar_count_d = solar_count_q + 2'd1;
					end
				end else if (solar_on_q && item_s1.pv_watts < pmad_pkg::SOLAR_OFF_W) begin
					if (solar_count_q == pmad_pkg::DEBOUNCE_LAST) begin
						solar_on_d          = 1'b0;
						solar_count_d       = '0;
						res_d.solar_stopped = 1'b1;
					end else begin
						solar_count_d = solar_count_q + 2'd1;
					end
				end else begin
					solar_count_d = '0;
				end
			end

			// battery
			if (!battery_is_low_q && item_s1.charge_percent < battery_low_percent_q) begin
				battery_is_low_d    = 1'b1;
				res_d.battery_low   = 1'b1;
				res_d.charge_report = item_s1.charge_percent;
			end else if (battery_is_low_q && {1'b0, item_s1.charge_percent} >= rec_level) begin
				battery_is_low_d        = 1'b0;
				res_d.battery_recovered = 1'b1;
				res_d.charge_report     = item_s1.charge_percent;
			end

			// grid
			if (grid_alerts_on_q) begin
				if (mains_live) begin
					grid_seen_d = 1'b1;
				end
				if ((grid_seen_q || mains_live) && !grid_down_q && !mains_live) begin
					if (grid_count_q == pmad_pkg::DEBOUNCE_LAST) begin
						grid_down_d       = 1'b1;
						grid_count_d      = '0;
						res_d.grid_lost   = 1'b1;
						res_d.grid_report = item_s1.grid_watts;
					end else begin
						grid_count_d = grid_count_q + 2'd1;
					end
				end else if (grid_down_q && mains_live) begin
					grid_down_d    = 1'b0;
					grid_count_d   = '0;
					res_d.grid_back = 1'b1;
				end else if (mains_live) begin
					grid_count_d = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1         <= 1'b0;
			valid_s2         <= 1'b0;
			solar_on_q       <= 1'b0;
			solar_count_q    <= '0;
			battery_is_low_q <= 1'b0;
			grid_seen_q      <= 1'b0;
			grid_down_q      <= 1'b0;
			grid_count_q     <= '0;
			fail_count_q     <= '0;
			fail_reported_q  <= 1'b0;
		end else begin
			if (take_s1) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2         <= 1'b1;
				solar_on_q       <= solar_on_d;
				solar_count_q    <= solar_count_d;
				battery_is_low_q <= battery_is_low_d;
				grid_seen_q      <= grid_seen_d;
				grid_down_q      <= grid_down_d;
				grid_count_q     <= grid_count_d;
				fail_count_q     <= fail_count_d;
				fail_reported_q  <= fail_reported_d;
			end else if (!result_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take_s1) begin
			item_s1 <= item;
		end
		if (adv_s2) begin
			result_s2 <= res_d;
		end
	end

	`ASSERT_IMPLIES(a_stall_full, clk, arst_n, item_stall, valid_s1 && valid_s2)
	`ASSERT_NEXT(a_solar_start_state, clk, arst_n, adv_s2 && res_d.solar_started, solar_on_q)
	`ASSERT_IMPLIES(a_logger_reported, clk, arst_n, valid_s2 && result_s2.logger_failed, fail_reported_q)
	`ASSERT_IMPLIES(a_grid_lost_down, clk, arst_n, valid_s2 && result_s2.grid_lost, grid_down_q)

endmodule

`default_nettype wire

FILE: test/testbench.sv
// testbench for the power monitor alarm detector: predicted alarms checked word by word
`timescale 1ns / 1ps

module testbench;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_stall;
	pmad_pkg::item_t   item = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	pmad_pkg::result_t result;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index = pmad_pkg::CFG_SOLAR_ON;
	logic [6:0]        cfg_data = '0;

	// register shadow
	bit          solar_en = 1'b0;
	bit          grid_en = 1'b0;
	bit          logger_en = 1'b0;
	int          low_level = 20;

	// detector shadow
	bit          sun_up, batt_flagged, mains_seen, mains_down, fail_flagged;
	int          sun_run, mains_run, fail_run;

	pmad_pkg::result_t alarm_queue[$];
	int          mismatches = 0;
	bit          idling_on = 1'b1;
	int          send_quiet = 0;
	int          recv_quiet = 0;
	int          stall_left = 0;
	int          hold_orders = 0;
	int          hold_taken = 0;

	power_monitor_alarm_detector DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic pmad_pkg::result_t predict_alarms(pmad_pkg::item_t w);
		pmad_pkg::result_t r;
		int pv, grid, mag, charge, rec;
		bit active;
		r = '0;
		pv = $signed(w.pv_watts);
		grid = $signed(w.grid_watts);
		charge = w.charge_percent;
		if (w.poll_ok) begin
			fail_run = 0;
			fail_flagged = 1'b0;
		end else begin
			if (fail_run < 5)
				fail_run++;
			if (fail_run == 5 && !fail_flagged) begin
				fail_flagged = 1'b1;
				r.logger_failed = logger_en;
			end
		end
		if (w.poll_ok && w.armed) begin
			if (solar_en) begin
				if (!sun_up && pv > 50) begin
					sun_run++;
					if (sun_run >= 3) begin
						sun_up = 1'b1;
						sun_run = 0;
						r.solar_started = 1'b1;
						r.pv_report = w.pv_watts;
					end
				end else if (sun_up && pv < 20) begin
					sun_run++;
					if (sun_run >= 3) begin
						sun_up = 1'b0;
						sun_run = 0;
						r.solar_stopped = 1'b1;
					end
				end else
					sun_run = 0;
			end
			rec = (low_level + 5 <= 100) ? low_level + 5 : 100;
			if (!batt_flagged && charge < low_level) begin
				batt_flagged = 1'b1;
				r.battery_low = 1'b1;
				r.charge_report = w.charge_percent;
			end else if (batt_flagged && charge >= rec) begin
				batt_flagged = 1'b0;
				r.battery_recovered = 1'b1;
				r.charge_report = w.charge_percent;
			end
			if (grid_en) begin
				mag = grid < 0 ? -grid : grid;
				active = mag > 100;
				if (active)
					mains_seen = 1'b1;
				if (mains_seen && !mains_down && !active) begin
					mains_run++;
					if (mains_run >= 3) begin
						mains_down = 1'b1;
						mains_run = 0;
						r.grid_lost = 1'b1;
						r.grid_report = w.grid_watts;
					end
				end else if (mains_down && active) begin
					mains_down = 1'b0;
					mains_run = 0;
					r.grid_back = 1'b1;
				end else if (active)
					mains_run = 0;
			end
		end
		return r;
	endfunction

	task automatic report(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			report($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	always @(posedge clk) begin
		pmad_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (alarm_queue.size() == 0)
				report("result word with nothing expected");
			else begin
				want = alarm_queue.pop_front();
				check_field("solar_started", 16'(result.solar_started),
					16'(want.solar_started));
				check_field("solar_stopped", 16'(result.solar_stopped),
					16'(want.solar_stopped));
				check_field("battery_low", 16'(result.battery_low), 16'(want.battery_low));
				check_field("battery_recovered", 16'(result.battery_recovered),
					16'(want.battery_recovered));
				check_field("grid_lost", 16'(result.grid_lost), 16'(want.grid_lost));
				check_field("grid_back", 16'(result.grid_back), 16'(want.grid_back));
				check_field("logger_failed", 16'(result.logger_failed),
					16'(want.logger_failed));
				check_field("pv_report", result.pv_report, want.pv_report);
				check_field("grid_report", result.grid_report, want.grid_report);
				check_field("charge_report", 16'(result.charge_report),
					16'(want.charge_report));
			end
		end
	end

	// receiver: random stall bursts, quiet stretches and ordered long hold-offs
	always @(posedge clk) begin
		if (hold_taken != hold_orders) begin
			hold_taken = hold_orders;
			stall_left = 60;
		end
		if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else if (recv_quiet > 0) begin
			recv_quiet--;
			result_stall <= 1'b0;
		end else if (idling_on && $urandom_range(0, 24) == 0) begin
			recv_quiet = $urandom_range(10, 40);
			result_stall <= 1'b0;
		end else if (idling_on && $urandom_range(0, 3) == 0) begin
			stall_left = $urandom_range(0, 5);
			result_stall <= 1'b1;
		end else
			result_stall <= 1'b0;
	end

	task automatic send_word(pmad_pkg::item_t w);
		if (send_quiet > 0)
			send_quiet--;
		else if (idling_on && $urandom_range(0, 24) == 0)
			send_quiet = $urandom_range(10, 40);
		else if (idling_on && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		do @(posedge clk); while (item_stall);
		alarm_queue.push_back(predict_alarms(w));
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (alarm_queue.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[6:0];
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			pmad_pkg::CFG_SOLAR_ON:  solar_en = val[0];
			pmad_pkg::CFG_GRID_ON:   grid_en = val[0];
			pmad_pkg::CFG_LOGGER_ON: logger_en = val[0];
			pmad_pkg::CFG_BATT_LOW:  low_level = val[6:0];
			default: ;
		endcase
	endtask

	task automatic set_config(bit solar, bit grid, bit logger, int level);
		wait_drained();
		write_reg(pmad_pkg::CFG_SOLAR_ON, solar);
		write_reg(pmad_pkg::CFG_GRID_ON, grid);
		write_reg(pmad_pkg::CFG_LOGGER_ON, logger);
		write_reg(pmad_pkg::CFG_BATT_LOW, level);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic pmad_pkg::item_t word_of(bit ok, bit armed, int pv, int grid,
		int charge);
		pmad_pkg::item_t w;
		w.poll_ok = ok;
		w.armed = armed;
		w.pv_watts = pv[15:0];
		w.grid_watts = grid[15:0];
		w.charge_percent = charge[6:0];
		return w;
	endfunction

	// shaped readings: runs above and below the solar levels, quiet and busy grid,
	// failure runs and charge around the threshold, with some raw noise
	function automatic pmad_pkg::item_t make_word(int mode);
		pmad_pkg::item_t w;
		logic [63:0] raw;
		int pv, grid, charge;
		pv = $urandom_range(0, 600) - 100;
		grid = $urandom_range(0, 1000) - 500;
		charge = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 127)
			: low_level + $urandom_range(0, 14) - 7;
		if (charge < 0)
			charge = 0;
		case (mode)
			1: pv = ($urandom_range(0, 9) == 0) ? 32767 : $urandom_range(51, 400);
			2: pv = ($urandom_range(0, 9) == 0) ? -32768 : $urandom_range(0, 69) - 50;
			3: grid = $urandom_range(0, 200) - 100;
			4: grid = ($urandom_range(0, 1) == 1) ? $urandom_range(101, 5000)
				: -$urandom_range(101, 32768);
			default: ;
		endcase
		w = word_of($urandom_range(0, 19) != 0, $urandom_range(0, 15) != 0, pv, grid, charge);
		if (mode == 5)
			w.poll_ok = ($urandom_range(0, 9) == 0);
		if (mode == 0) begin
			raw = {$urandom, $urandom};
			w = raw[$bits(pmad_pkg::item_t)-1:0];
		end
		return w;
	endfunction

	task automatic run_random(int count);
		int sent, mode, len;
		sent = 0;
		while (sent < count) begin
			mode = $urandom_range(0, 6);
			len = (mode == 5) ? $urandom_range(1, 8) : $urandom_range(1, 7);
			repeat (len) begin
				send_word(make_word(mode));
				sent++;
			end
		end
	endtask

	task automatic test_reset_defaults();
		int k;
		for (k = 0; k < 3; k++)
			send_word(word_of(1, 1, 400, 3000, 50));
		send_word(word_of(1, 1, 0, 0, 5));
		send_word(word_of(1, 1, 0, 0, 25));
		for (k = 0; k < 6; k++)
			send_word(word_of(0, 1, 0, 0, 50));
		send_word(word_of(1, 1, 0, 0, 50));
	endtask

	task automatic test_alarm_sequences();
		int k;
		set_config(1, 1, 1, 20);
		send_word(word_of(1, 1, 32767, 0, 100));
		send_word(word_of(1, 1, 51, 32767, 127));
		send_word(word_of(1, 1, 51, -32768, 0));
		send_word(word_of(1, 1, 50, 100, 24));
		send_word(word_of(1, 1, 19, -100, 25));
		send_word(word_of(1, 1, -32768, -100, 30));
		send_word(word_of(1, 0, 0, 5000, 0));
		send_word(word_of(0, 1, 0, 5000, 0));
		send_word(word_of(1, 1, 19, 101, 50));
		send_word(word_of(1, 1, 20, -101, 50));
		for (k = 0; k < 6; k++)
			send_word(word_of(0, k[0], 32767, -32768, 127));
		send_word(word_of(1, 0, 0, 0, 0));
		for (k = 0; k < 5; k++)
			send_word(word_of(0, 1, 0, 0, 50));
	endtask

	task automatic test_battery_levels();
		set_config(1, 1, 1, 100);
		send_word(word_of(1, 1, 0, 0, 99));
		send_word(word_of(1, 1, 0, 0, 100));
		set_config(0, 0, 0, 127);
		send_word(word_of(1, 1, 0, 0, 126));
		send_word(word_of(1, 1, 0, 0, 99));
		send_word(word_of(1, 1, 0, 0, 100));
		send_word(word_of(1, 1, 0, 0, 127));
		set_config(1, 0, 1, 0);
		send_word(word_of(1, 1, 0, 0, 0));
		set_config(0, 1, 0, 96);
		send_word(word_of(1, 1, 0, 0, 95));
		send_word(word_of(1, 1, 0, 0, 99));
		send_word(word_of(1, 1, 0, 0, 101));
	endtask

	task automatic test_random_settings();
		set_config(1, 1, 1, 20);
		run_random(140);
		set_config(0, 0, 0, 0);
		run_random(140);
		set_config(1, 0, 1, 100);
		run_random(140);
		set_config(1, 1, 1, 127);
		run_random(140);
		set_config(0, 1, 0, 5);
		run_random(140);
		set_config($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
			$urandom_range(0, 127));
		run_random(140);
	endtask

	task automatic test_long_hold();
		set_config(1, 1, 1, 40);
		hold_orders++;
		run_random(30);
	endtask

	task automatic test_sender_pause();
		run_random(20);
		wait_drained();
		run_random(20);
	endtask

	task automatic test_steady_tail();
		set_config(1, 1, 1, 30);
		idling_on = 1'b0;
		run_random(100);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_alarm_sequences();
		test_battery_levels();
		test_random_settings();
		test_long_hold();
		test_sender_pause();
		test_steady_tail();
		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("power_monitor_alarm_detector verification clean");
		else
			$display("power_monitor_alarm_detector verification failed");
		$finish;
	end

	initial begin
		#400000;
		$display("power_monitor_alarm_detector verification failed");
		$finish;
	end

endmodule
